// ===== design/srft_pkg.sv =====
// Shared types, constants and codes for the server resource fit tracker.
`timescale 1ns / 1ps
`default_nettype none

package srft_pkg;

   localparam int SERVER_COUNT_DEF = 64;
   localparam int NUM_DIMS_DEF     = 4;

   localparam int AMT_W = 31;
   localparam int REM_W = 32;
   localparam int EPS_W = 16;

   localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_CHECK = 2'd1;
   localparam logic [1:0] FUNC_PLACE = 2'd2;
   localparam logic [1:0] FUNC_NOP   = 2'd3;

   typedef struct packed {
      logic [1:0]       func;
      logic [7:0]       service_id;
      logic [5:0]       server;
      logic [1:0]       dim;
      logic [AMT_W-1:0] unit_amount;
      logic [AMT_W-1:0] total_amount;
      logic [AMT_W-1:0] fluid_amount;
      logic             last_dim;
   } req_type;

   typedef struct packed {
      logic                    fits;
      logic signed [REM_W-1:0] remaining;
      logic [AMT_W-1:0]        fluid_used;
      logic [7:0]              placed_service;
      logic                    done_res;
   } rsp_type;

   // One table entry: unit capacity, remaining capacity, fluid load.
   typedef struct packed {
      logic [AMT_W-1:0]        unit_cap;
      logic signed [REM_W-1:0] remaining;
      logic [AMT_W-1:0]        fluid_used;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic read;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_busy;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/server_resource_fit_tracker_core.sv =====
// Top level of the server resource fit tracker: sequencer plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// Server resource fit tracker. Keeps, for each (server, dimension) entry,
// the unit capacity and fluid load (unsigned Q15.16), the remaining capacity
// (signed Q16.16). Each request beat addresses one entry and either loads
// it (sets capacities, clears fluid load), checks a service against it
// (unit and total requirement must each stay at or below the stored value
// minus epsilon; the outcome is ANDed across the dimensions of a request and
// restarts after a beat marked last_dim), or places a service (subtract the
// total requirement, saturating at -2^31; add the fluid need, saturating at
// 2^31-1). Every request beat yields exactly one response beat.
// Sequence: an item passes capture, registered table read, then compute
// and write back, which loads its response beat; req_stall holds off the
// next request until the item in flight is committed. A response waiting
// on rsp_stall does not block the next request from being captured and
// read; only its write-back waits. Entry tables come out of reset
// undefined: load an entry before checking or placing against it. Addresses
// beyond SERVER_COUNT or NUM_DIMS leave the tables untouched, report zeros
// and fail any check. Write epsilon through csr_wr_en/csr_wr_data only
// while the block is idle; epsilon resets to 1 (one LSB of Q16.16).

module server_resource_fit_tracker_core #(
   parameter int SERVER_COUNT = srft_pkg::SERVER_COUNT_DEF,
   parameter int NUM_DIMS     = srft_pkg::NUM_DIMS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire srft_pkg::req_type          req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output srft_pkg::rsp_type               rsp_payload,
   input  wire logic                       csr_wr_en,
   input  wire logic [srft_pkg::EPS_W-1:0] csr_wr_data
);

   srft_pkg::ctrl_cmd_type  cmd;
   srft_pkg::dp_status_type status;

   // Sequencer: capture the beat, issue the table read, commit when the
   // response register is free.
   srft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: entry table, compare and saturating update, response register.
   srft_dpath #(
      .SERVER_COUNT (SERVER_COUNT),
      .NUM_DIMS     (NUM_DIMS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule

`default_nettype wire

// ===== design/srft_ctrl.sv =====
// Sequencer for the fit tracker: capture, table read, compute and write back.
`timescale 1ns / 1ps
`default_nettype none

module srft_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire srft_pkg::dp_status_type status,
   output srft_pkg::ctrl_cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_READ   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall   = (state_ff != ST_IDLE);
   assign cmd.capture = (state_ff == ST_IDLE) && req_valid;
   assign cmd.read    = (state_ff == ST_READ);
   assign cmd.commit  = (state_ff == ST_COMMIT) && !status.out_busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the result register can take the beat
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

// ===== design/srft_dpath.sv =====
// Datapath for the fit tracker: entry table, fit compare, place update, result register.
`timescale 1ns / 1ps
`default_nettype none

module srft_dpath #(
   parameter int SERVER_COUNT = srft_pkg::SERVER_COUNT_DEF,
   parameter int NUM_DIMS     = srft_pkg::NUM_DIMS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire srft_pkg::ctrl_cmd_type        cmd,
   output srft_pkg::dp_status_type            status,
   input  wire srft_pkg::req_type             req_payload,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output srft_pkg::rsp_type                  rsp_payload,
   input  wire logic                          csr_wr_en,
   input  wire logic [srft_pkg::EPS_W-1:0]    csr_wr_data
);

   localparam int ENTRIES = SERVER_COUNT * NUM_DIMS;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CMP_W   = srft_pkg::REM_W + 2;

   srft_pkg::req_type   req_ff;
   srft_pkg::entry_type rd_entry_ff;
   srft_pkg::entry_type wr_entry;
   srft_pkg::entry_type entry_mem [ENTRIES];
   srft_pkg::rsp_type   rsp_ff;
   srft_pkg::rsp_type   rsp_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                fit_acc_ff;
   logic                fit_acc_in;
   logic [srft_pkg::EPS_W-1:0] eps_ff;

   logic [31:0]      idx_wide;
   logic [IDX_W-1:0] idx;
   logic             addr_ok;
   logic             wr_en;

   logic signed [CMP_W-1:0] unit_lhs;
   logic signed [CMP_W-1:0] unit_rhs;
   logic signed [CMP_W-1:0] total_lhs;
   logic signed [CMP_W-1:0] total_rhs;
   logic                    check_ok;
   logic                    fit_new;

   logic signed [srft_pkg::REM_W:0]   rem_diff;
   logic signed [srft_pkg::REM_W-1:0] rem_sat;
   logic [srft_pkg::AMT_W:0]          fl_sum;
   logic [srft_pkg::AMT_W-1:0]        fl_sat;

   // Flat entry index; multiplication by a constant.
   assign idx_wide = 32'(req_ff.server) * 32'(NUM_DIMS) + 32'(req_ff.dim);
   assign idx      = idx_wide[IDX_W-1:0];
   assign addr_ok  = (32'(req_ff.server) < 32'(SERVER_COUNT)) &&
                     (32'(req_ff.dim) < 32'(NUM_DIMS));

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_payload;
   end

   always_ff @(posedge clock) begin
      if (reset)          eps_ff <= srft_pkg::EPS_RESET;
      else if (csr_wr_en) eps_ff <= csr_wr_data;
   end

   // Table: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.read) rd_entry_ff <= entry_mem[idx];
      if (wr_en)    entry_mem[idx] <= wr_entry;
   end

   // Fit compare against capacity minus epsilon.
   assign unit_lhs  = signed'({3'b000, req_ff.unit_amount});
   assign unit_rhs  = signed'({3'b000, rd_entry_ff.unit_cap}) -
                      signed'({18'd0, eps_ff});
   assign total_lhs = signed'({3'b000, req_ff.total_amount});
   assign total_rhs = signed'({{2{rd_entry_ff.remaining[srft_pkg::REM_W-1]}},
                               rd_entry_ff.remaining}) -
                      signed'({18'd0, eps_ff});
   assign check_ok  = addr_ok && (unit_lhs <= unit_rhs) && (total_lhs <= total_rhs);
   assign fit_new   = fit_acc_ff && check_ok;

   // Place: saturating subtract and add.
   assign rem_diff = signed'({rd_entry_ff.remaining[srft_pkg::REM_W-1],
                              rd_entry_ff.remaining}) -
                     signed'({2'b00, req_ff.total_amount});
   assign rem_sat  = (rem_diff[srft_pkg::REM_W] != rem_diff[srft_pkg::REM_W-1]) ?
                     {1'b1, {(srft_pkg::REM_W-1){1'b0}}} :
                     rem_diff[srft_pkg::REM_W-1:0];
   assign fl_sum   = {1'b0, rd_entry_ff.fluid_used} + {1'b0, req_ff.fluid_amount};
   assign fl_sat   = fl_sum[srft_pkg::AMT_W] ? {srft_pkg::AMT_W{1'b1}} :
                     fl_sum[srft_pkg::AMT_W-1:0];

   always_comb begin
      wr_entry = rd_entry_ff;
      wr_en    = 1'b0;
      case (req_ff.func)
         srft_pkg::FUNC_LOAD: begin
            wr_entry.unit_cap   = req_ff.unit_amount;
            wr_entry.remaining  = signed'({1'b0, req_ff.total_amount});
            wr_entry.fluid_used = '0;
            wr_en               = cmd.commit && addr_ok;
         end
         srft_pkg::FUNC_PLACE: begin
            wr_entry.remaining  = rem_sat;
            wr_entry.fluid_used = fl_sat;
            wr_en               = cmd.commit && addr_ok;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_in.fits           = (req_ff.func == srft_pkg::FUNC_CHECK) ? fit_new : 1'b0;
      rsp_in.remaining      = addr_ok ? wr_entry.remaining : '0;
      rsp_in.fluid_used     = addr_ok ? wr_entry.fluid_used : '0;
      rsp_in.placed_service = req_ff.service_id;
      rsp_in.done_res       = req_ff.last_dim;
   end

   always_comb begin
      fit_acc_in = fit_acc_ff;
      if (cmd.commit) begin
         if (req_ff.last_dim)                         fit_acc_in = 1'b1;
         else if (req_ff.func == srft_pkg::FUNC_CHECK) fit_acc_in = fit_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) fit_acc_ff <= 1'b1;
      else       fit_acc_ff <= fit_acc_in;
   end

   // Result register: load on commit, drop once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit)                  rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   assign status.out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_ff;

endmodule

`default_nettype wire

// ===== dv/fit_tracker_monitor.sv =====
// Response checker for the fit tracker: mirrors the entry tables, checks each beat.
`timescale 1ns / 1ps

module fit_tracker_monitor
   import srft_pkg::*;
#(
   parameter int SERVER_COUNT = SERVER_COUNT_DEF,
   parameter int NUM_DIMS     = NUM_DIMS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  req_type          req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  rsp_type          rsp_payload,
   input  logic             csr_wr_en,
   input  logic [EPS_W-1:0] csr_wr_data,
   output int               pending,
   output int               errors
);

   localparam int     ENTRIES  = SERVER_COUNT * NUM_DIMS;
   localparam longint REM_MIN  = -64'sd2147483648;
   localparam longint LOAD_MAX = 64'sd2147483647;

   logic [AMT_W-1:0]        unit_cap_q [ENTRIES];
   logic signed [REM_W-1:0] remain_q   [ENTRIES];
   logic [AMT_W-1:0]        fluid_q    [ENTRIES];
   bit                      fit_run;
   logic [EPS_W-1:0]        margin;
   rsp_type                 awaited_results [$];
   int                      rsp_beats;

   initial begin
      errors    = 0;
      pending   = 0;
      rsp_beats = 0;
      fit_run   = 1'b1;
      margin    = EPS_RESET;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] response beat %0d: %s", $realtime, rsp_beats, what);
      errors++;
   endtask

   // Apply one request beat to the mirrored tables and return the response it earns.
   function automatic rsp_type track_entry(input req_type b);
      rsp_type r;
      bit      in_range;
      bit      ok;
      int      idx;
      longint  sum;
      r        = '0;
      in_range = (int'(b.server) < SERVER_COUNT) && (int'(b.dim) < NUM_DIMS);
      idx      = in_range ? int'(b.server) * NUM_DIMS + int'(b.dim) : 0;
      if (in_range) begin
         case (b.func)
            FUNC_LOAD: begin
               unit_cap_q[idx] = b.unit_amount;
               remain_q[idx]   = {1'b0, b.total_amount};
               fluid_q[idx]    = '0;
            end
            FUNC_PLACE: begin
               sum = longint'(remain_q[idx]) - longint'(b.total_amount);
               remain_q[idx] = (sum < REM_MIN) ? REM_MIN[REM_W-1:0] : sum[REM_W-1:0];
               sum = longint'(fluid_q[idx]) + longint'(b.fluid_amount);
               fluid_q[idx] = (sum > LOAD_MAX) ? LOAD_MAX[AMT_W-1:0] : sum[AMT_W-1:0];
            end
            default: ;
         endcase
         r.remaining  = remain_q[idx];
         r.fluid_used = fluid_q[idx];
      end
      if (b.func == FUNC_CHECK) begin
         ok = in_range &&
              longint'(b.unit_amount) <= longint'(unit_cap_q[idx]) - longint'(margin) &&
              longint'(b.total_amount) <= longint'(remain_q[idx]) - longint'(margin);
         fit_run = fit_run && ok;
         r.fits  = fit_run;
      end
      if (b.last_dim)
         fit_run = 1'b1;
      r.placed_service = b.service_id;
      r.done_res       = b.last_dim;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         awaited_results.delete();
         fit_run = 1'b1;
         margin  = EPS_RESET;
      end else begin
         if (csr_wr_en)
            margin = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            rsp_beats++;
            if (awaited_results.size() == 0) begin
               report_mismatch("response beat with no request outstanding");
            end else begin
               want = awaited_results.pop_front();
               if (rsp_payload.fits !== want.fits)
                  report_mismatch($sformatf("fits %b, expected %b",
                                            rsp_payload.fits, want.fits));
               if (rsp_payload.remaining !== want.remaining)
                  report_mismatch($sformatf("remaining %0d, expected %0d",
                                            rsp_payload.remaining, want.remaining));
               if (rsp_payload.fluid_used !== want.fluid_used)
                  report_mismatch($sformatf("fluid_used %0d, expected %0d",
                                            rsp_payload.fluid_used, want.fluid_used));
               if (rsp_payload.placed_service !== want.placed_service)
                  report_mismatch($sformatf("placed_service %0h, expected %0h",
                                            rsp_payload.placed_service, want.placed_service));
               if (rsp_payload.done_res !== want.done_res)
                  report_mismatch($sformatf("done_res %b, expected %b",
                                            rsp_payload.done_res, want.done_res));
            end
         end
         if (req_valid && !req_stall)
            awaited_results.push_back(track_entry(req_payload));
      end
      pending = awaited_results.size();
   end

endmodule

// ===== dv/testbench.sv =====
// Top of the fit tracker testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module testbench;
   import srft_pkg::*;

   // Time the block takes to answer a request beat; settle a little longer than that.
   localparam int LATENCY         = 3;
   // Cycles without any beat moving before the run is declared hung.
   localparam int STALL_LIMIT     = 4000;
   localparam int ITEMS_PER_PHASE = 510;
   localparam int ENTRY_COUNT     = SERVER_COUNT_DEF * NUM_DIMS_DEF;
   localparam logic [AMT_W-1:0] AMT_TOP = '1;
   localparam logic [AMT_W-1:0] ONE_Q   = 31'd65536;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   req_type          req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   rsp_type          rsp_payload;
   logic             csr_wr_en   = 1'b0;
   logic [EPS_W-1:0] csr_wr_data = '0;

   int mismatches;
   int pending;
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int idle_cycles       = 0;
   int loads_sent        = 0;
   int checks_sent       = 0;
   int places_sent       = 0;
   int others_sent       = 0;
   int beats_sent        = 0;
   bit loaded [ENTRY_COUNT];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   server_resource_fit_tracker_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   fit_tracker_monitor monitor (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pending     (pending),
      .errors      (mismatches)
   );

   // Receiver side: stall at random at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < receiver_idle_pct);
   end

   // Hang detector: restart the count whenever a beat moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("No beat moved for %0d cycles, %0d responses outstanding",
                  STALL_LIMIT, pending);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Amount with a bias toward the edges: zero, all ones, full 31-bit random,
   // otherwise random below 2^span so capacities and requests land near each other.
   function automatic logic [AMT_W-1:0] pick_amount(input int unsigned span);
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 4)
         return '0;
      if (sel < 8)
         return AMT_TOP;
      if (sel < 16)
         return AMT_W'($urandom);
      return AMT_W'($urandom & ((32'd1 << span) - 32'd1));
   endfunction

   // Present one request beat, idling first at the sender's rate, and hold it
   // until the block takes it. Returns on the accepting edge with valid still high.
   task automatic send_beat(input req_type b);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      beats_sent++;
      case (b.func)
         FUNC_LOAD: begin
            loads_sent++;
            loaded[int'(b.server) * NUM_DIMS_DEF + int'(b.dim)] = 1'b1;
         end
         FUNC_CHECK: checks_sent++;
         FUNC_PLACE: places_sent++;
         default:    others_sent++;
      endcase
   endtask

   // Send one item. Entries come out of reset undefined, so an entry that was
   // never loaded gets a load first; the load carries last_dim low so it sits
   // inside any request in progress without closing it.
   task automatic issue(input logic [1:0] func, input logic [7:0] sid,
                        input logic [5:0] server, input logic [1:0] dim,
                        input logic [AMT_W-1:0] unit_amt, total_amt, fluid_amt,
                        input logic last);
      req_type b;
      int      idx;
      idx = int'(server) * NUM_DIMS_DEF + int'(dim);
      if (func != FUNC_LOAD && !loaded[idx]) begin
         b = '{FUNC_LOAD, sid, server, dim, pick_amount(20), pick_amount(24),
               pick_amount(31), 1'b0};
         send_beat(b);
      end
      b = '{func, sid, server, dim, unit_amt, total_amt, fluid_amt, last};
      send_beat(b);
   endtask

   // Drop valid and hold off until every response has come back, then let the
   // pipeline settle. Pending is sampled at the falling edge, clear of the
   // monitor's update at the rising edge.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (pending != 0);
      repeat (LATENCY + 3) @(posedge clock);
   endtask

   task automatic write_margin(input logic [EPS_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Random traffic: mostly well-formed requests (checks or places over a run
   // of dimensions on one server, last_dim on the final one), plus fresh loads,
   // noise beats of any operation, truncated requests and the odd full drain.
   task automatic run_phase(input int count, input int send_idle, input int recv_idle);
      int          target;
      int unsigned roll;
      int unsigned ndims;
      int unsigned first;
      logic [5:0]  server;
      logic [7:0]  sid;
      logic [1:0]  op;
      logic [1:0]  dim;
      bit          truncate;
      sender_idle_pct   = send_idle;
      receiver_idle_pct = recv_idle;
      target = beats_sent + count;
      while (beats_sent < target) begin
         roll   = $urandom_range(0, 99);
         server = 6'($urandom_range(0, SERVER_COUNT_DEF - 1));
         sid    = 8'($urandom);
         if (roll < 12) begin
            issue(FUNC_LOAD, sid, server, 2'($urandom), pick_amount(20), pick_amount(24),
                  pick_amount(31), 1'($urandom));
         end else if (roll < 18) begin
            // noise: any operation, any field, any last_dim
            issue(2'($urandom), sid, server, 2'($urandom), pick_amount(31),
                  pick_amount(31), pick_amount(31), 1'($urandom));
         end else if (roll < 19) begin
            drain_and_settle();
         end else begin
            ndims    = $urandom_range(1, NUM_DIMS_DEF);
            first    = $urandom_range(0, NUM_DIMS_DEF - 1);
            op       = ($urandom_range(0, 99) < 60) ? FUNC_CHECK : FUNC_PLACE;
            truncate = $urandom_range(0, 99) < 8;
            for (int k = 0; k < ndims; k++) begin
               dim = 2'((first + k) % NUM_DIMS_DEF);
               if (op == FUNC_CHECK)
                  issue(op, sid, server, dim, pick_amount(20),
                        pick_amount(23), pick_amount(31), k == ndims - 1 && !truncate);
               else
                  issue(op, sid, server, dim, pick_amount(20),
                        pick_amount(21), pick_amount(26), k == ndims - 1 && !truncate);
            end
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, margin at its reset value of one LSB.
      sender_idle_pct   = 25;
      receiver_idle_pct = 83;
      issue(FUNC_LOAD,  8'h00, 6'd0,  2'd0, 31'd10 * ONE_Q, 31'd100 * ONE_Q, AMT_TOP, 1'b0);
      issue(FUNC_LOAD,  8'h01, 6'd63, 2'd3, AMT_TOP, AMT_TOP, '0, 1'b1);
      issue(FUNC_LOAD,  8'h02, 6'd0,  2'd1, '0, '0, '0, 1'b0);
      // exactly at capacity minus margin on both tests: fits
      issue(FUNC_CHECK, 8'hFF, 6'd0,  2'd0, 31'd10 * ONE_Q - 31'd1,
            31'd100 * ONE_Q - 31'd1, '0, 1'b0);
      issue(FUNC_CHECK, 8'hFF, 6'd63, 2'd3, AMT_TOP - 31'd1, AMT_TOP - 31'd1, '0, 1'b1);
      // one LSB over: fails, and the failure sticks for the rest of the request
      issue(FUNC_CHECK, 8'h10, 6'd0,  2'd0, 31'd10 * ONE_Q, '0, '0, 1'b0);
      issue(FUNC_CHECK, 8'h10, 6'd63, 2'd3, '0, '0, '0, 1'b0);
      // a load closing the request still rearms the fit flag
      issue(FUNC_LOAD,  8'h10, 6'd0,  2'd2, 31'd5 * ONE_Q, 31'd5 * ONE_Q, '0, 1'b1);
      issue(FUNC_CHECK, 8'h11, 6'd0,  2'd2, '0, '0, '0, 1'b1);
      // zero capacity cannot hold even a zero request once the margin is taken
      issue(FUNC_CHECK, 8'h12, 6'd0,  2'd1, '0, '0, '0, 1'b1);
      issue(FUNC_PLACE, 8'h20, 6'd0,  2'd0, '0, 31'd40 * ONE_Q, 31'd3 * ONE_Q, 1'b0);
      issue(FUNC_NOP,   8'h21, 6'd0,  2'd0, AMT_TOP, AMT_TOP, AMT_TOP, 1'b0);
      // drive remaining negative, then into the floor; fluid load into its ceiling
      issue(FUNC_PLACE, 8'h22, 6'd0,  2'd0, AMT_TOP, AMT_TOP, AMT_TOP, 1'b0);
      issue(FUNC_PLACE, 8'h22, 6'd0,  2'd0, '0, AMT_TOP, AMT_TOP, 1'b1);
      issue(FUNC_CHECK, 8'h23, 6'd0,  2'd0, '0, '0, '0, 1'b1);
      issue(FUNC_PLACE, 8'h24, 6'd63, 2'd3, '0, '0, '0, 1'b1);
      // reload clears the fluid load
      issue(FUNC_LOAD,  8'h25, 6'd0,  2'd0, 31'd1, 31'd1, AMT_TOP, 1'b1);
      issue(FUNC_CHECK, 8'h26, 6'd0,  2'd0, '0, '0, '0, 1'b1);
      issue(FUNC_NOP,   8'hAA, 6'd63, 2'd3, '0, '0, '0, 1'b1);
      drain_and_settle();

      // Zero margin: a request equal to capacity fits.
      write_margin('0);
      issue(FUNC_CHECK, 8'h30, 6'd0,  2'd2, 31'd5 * ONE_Q, 31'd5 * ONE_Q, '0, 1'b1);
      run_phase(ITEMS_PER_PHASE, 25, 83);
      drain_and_settle();

      // Widest margin: just under one unit of headroom is required.
      write_margin('1);
      issue(FUNC_LOAD,  8'h31, 6'd0,  2'd2, 31'd5 * ONE_Q, 31'd5 * ONE_Q, '0, 1'b0);
      issue(FUNC_CHECK, 8'h31, 6'd0,  2'd2, 31'd4 * ONE_Q + 31'd1, 31'd4 * ONE_Q + 31'd1,
            '0, 1'b1);
      run_phase(ITEMS_PER_PHASE, 83, 25);
      drain_and_settle();

      // Some margin in between, with no idling on either side.
      write_margin(EPS_W'($urandom_range(1, 65534)));
      run_phase(ITEMS_PER_PHASE, 0, 0);
      drain_and_settle();

      $display("Covered %0d request beats: %0d loads, %0d checks, %0d places, %0d no-ops",
               beats_sent, loads_sent, checks_sent, places_sent, others_sent);
      $display("Margins 1, 0, max and a random value; sender and receiver stalls swapped");
      if (mismatches == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
